/* sv/ils_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg: shared types for the indexed LIFO stack
// Request mode codes and result status codes.
// ----------------------------------------------------------------------------
package ils_pkg;

    typedef enum logic [2:0] {
        MODE_PUSH   = 3'd0,
        MODE_POP    = 3'd1,
        MODE_PEEK   = 3'd2,
        MODE_INSERT = 3'd3,
        MODE_REMOVE = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

endpackage

/* sv/indexed_lifo_stack_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_lifo_stack_unit: bounded stack with positional insert and remove
// Register-array stack; one request in, one result word out.
// ----------------------------------------------------------------------------
// A bounded stack of DEPTH entries held in a register array, entry 0 at the
// bottom. Each request word carries a mode (push, pop, peek, insert at a
// position, remove at a position) and returns one result word with the top
// entry, the entry count and a status (ok, empty, bad position, full). A
// request is registered on entry, the whole array is shifted in parallel when
// it executes, and the result is held in an output register, so a request
// passes the request register, then the output register; one request word
// is taken every cycle while results are drained. The single parallel update
// of the register array sets that figure of one word per cycle. Unused mode
// codes act as peek. Entries are not cleared at reset; only filled entries are
// ever shown, and an empty stack reports a top value of zero.
// ----------------------------------------------------------------------------
module indexed_lifo_stack_unit
    import ils_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [2:0]                   mode,
    input  logic [$clog2(DEPTH+1)-1:0]   position,
    input  logic [DATA_WIDTH-1:0]        item_value,
    // result channel
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [DATA_WIDTH-1:0]        top_value,
    output logic [$clog2(DEPTH+1)-1:0]   entry_count,
    output logic [1:0]                   status
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // ---------------- request register ----------------
    logic                  req_valid_reg;
    logic [2:0]            mode_reg;
    logic [CNT_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;

    // ---------------- stack state ----------------
    logic [DATA_WIDTH-1:0] entries_reg  [DEPTH];
    logic [DATA_WIDTH-1:0] entries_next [DEPTH];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    // ---------------- result register ----------------
    logic                  rsp_valid_reg;
    logic [DATA_WIDTH-1:0] top_reg;
    logic [CNT_W-1:0]      cnt_out_reg;
    status_t               status_reg;

    logic                  advance;
    logic                  exec;
    status_t               status_next;
    logic [DATA_WIDTH-1:0] top_next;
    logic [CNT_W-1:0]      top_pos;

    // Decoded operation that actually changes the array
    logic do_push;
    logic do_insert;
    logic do_remove;
    logic is_empty;
    logic is_full;

    // The result register frees up when empty or when its word is taken
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign exec      = req_valid_reg && advance;
    // Hold the request register while a pending request cannot move on
    assign req_stall = req_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            req_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            mode_reg <= mode;
            pos_reg  <= position;
            val_reg  <= item_value;
        end
    end

    // ---------------- operation decode ----------------
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == DEPTH_C);

    always_comb
    begin
        status_next = ST_OK;
        do_push     = 1'b0;
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        count_next  = count_reg;
        unique case (mode_t'(mode_reg))
            MODE_PUSH:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_push    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_POP:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            MODE_INSERT:
            begin
                // position check first, then capacity
                if (pos_reg > count_reg)
                begin
                    status_next = ST_BADPOS;
                end
                else if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_insert  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_REMOVE:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (pos_reg >= count_reg)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    do_remove  = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                // peek, and unused codes behave as peek
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
            end
        endcase
    end

    // ---------------- per-entry shift logic ----------------
    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_entry
        localparam logic [CNT_W-1:0] IDX_C = CNT_W'(gi);
        logic [DATA_WIDTH-1:0] below;
        logic [DATA_WIDTH-1:0] above;

        if (gi == 0)
        begin : g_bottom
            assign below = '0;
        end
        else
        begin : g_below
            assign below = entries_reg[gi-1];
        end

        if (gi == DEPTH - 1)
        begin : g_topmost
            assign above = '0;
        end
        else
        begin : g_above
            assign above = entries_reg[gi+1];
        end

        always_comb
        begin
            entries_next[gi] = entries_reg[gi];
            if (do_push && (IDX_C == count_reg))
            begin
                entries_next[gi] = val_reg;
            end
            else if (do_insert && (IDX_C == pos_reg))
            begin
                entries_next[gi] = val_reg;
            end
            else if (do_insert && (IDX_C > pos_reg) && (IDX_C <= count_reg))
            begin
                // move up by one
                entries_next[gi] = below;
            end
            else if (do_remove && (IDX_C >= pos_reg) && ((IDX_C + 1'b1) < count_reg))
            begin
                // move down by one
                entries_next[gi] = above;
            end
        end
    end

    // Top of the stack after the operation
    assign top_pos  = count_next - 1'b1;
    assign top_next = (count_next == '0) ? '0 : entries_next[top_pos[IDX_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                count_reg <= count_next;
            end
            if (advance)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            top_reg     <= top_next;
            cnt_out_reg <= count_next;
            status_reg  <= status_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign top_value   = top_reg;
    assign entry_count = cnt_out_reg;
    assign status      = status_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond depth");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !exec |=> count_reg == $past(count_reg))
        else $error("entry count moved without an executed request");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == ST_FULL) |-> cnt_out_reg == DEPTH_C)
        else $error("full status with spare room");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == ST_EMPTY) |-> (cnt_out_reg == '0 && top_reg == '0))
        else $error("empty status on a non-empty stack");

    a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> cnt_out_reg == count_reg)
        else $error("result count differs from stored count");

endmodule

/* tb/indexed_lifo_stack_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_lifo_stack_unit_tb: self-checking bench for the indexed LIFO stack
// Drives request words in random bursts, stalls the result side on a pattern
// of its own, predicts every result word from a shadow copy of the stack and
// compares each field as it drains. Covers push, pop, peek, positional insert
// and remove, the empty and full edges, bad positions and the spare mode codes.
// ----------------------------------------------------------------------------
module indexed_lifo_stack_unit_tb;
    import ils_pkg::*;

    localparam int DEPTH          = 16;
    localparam int DATA_WIDTH     = 32;
    localparam int POS_W          = $clog2(DEPTH + 1);
    localparam int RANDOM_WORDS   = 1400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Mode codes left unused by the package; the block treats them as peek.
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]            mode;
        logic [POS_W-1:0]      position;
        logic [DATA_WIDTH-1:0] value;
    } stack_req_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] top;
        logic [POS_W-1:0]      count;
        status_t               status;
    } stack_rsp_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_LONG
    } stall_style_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  req_valid   = 1'b0;
    logic                  req_stall;
    logic [2:0]            mode        = '0;
    logic [POS_W-1:0]      position    = '0;
    logic [DATA_WIDTH-1:0] item_value  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall   = 1'b0;
    logic [DATA_WIDTH-1:0] top_value;
    logic [POS_W-1:0]      entry_count;
    logic [1:0]            status;

    // Request words waiting to be driven, and the result words they will cause.
    stack_req_t pending_words[$];
    stack_rsp_t expected_results[$];

    // Shadow copy of the stack, advanced once per accepted request word.
    logic [DATA_WIDTH-1:0] shadow_entries[DEPTH];
    int                    shadow_fill = 0;

    // Rough fill level seen by the stimulus generator, used to aim positions.
    int           gen_fill        = 0;
    int           words_queued    = 0;
    int           words_taken     = 0;
    int           mismatch_count  = 0;
    int           burst_left      = 0;
    int           gap_left        = 0;
    int           pattern_left    = 0;
    int           stall_run       = 0;
    int           quiet_cycles    = 0;
    stall_style_t stall_style     = STALL_NONE;
    stack_req_t   next_word;
    stack_rsp_t   want;

    indexed_lifo_stack_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .mode        (mode),
        .position    (position),
        .item_value  (item_value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .top_value   (top_value),
        .entry_count (entry_count),
        .status      (status)
    );

    always #4 clk = ~clk;

    // Hold reset low from the start, then release it for good.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Apply one request word to the shadow stack and return the result word
    // the block must produce for it.
    function automatic stack_rsp_t apply_stack_request(input stack_req_t rq);
        stack_rsp_t rs;
        status_t    st;
        int         i;
        st = ST_OK;
        case (rq.mode)
            MODE_PUSH:
                if (shadow_fill >= DEPTH)
                    st = ST_FULL;
                else
                begin
                    shadow_entries[shadow_fill] = rq.value;
                    shadow_fill++;
                end
            MODE_POP:
                if (shadow_fill == 0)
                    st = ST_EMPTY;
                else
                    shadow_fill--;
            MODE_INSERT:
                // Position is checked before fullness.
                if (rq.position > shadow_fill)
                    st = ST_BADPOS;
                else if (shadow_fill >= DEPTH)
                    st = ST_FULL;
                else
                begin
                    for (i = shadow_fill; i > rq.position; i--)
                        shadow_entries[i] = shadow_entries[i - 1];
                    shadow_entries[rq.position] = rq.value;
                    shadow_fill++;
                end
            MODE_REMOVE:
                if (shadow_fill == 0)
                    st = ST_EMPTY;
                else if (rq.position >= shadow_fill)
                    st = ST_BADPOS;
                else
                begin
                    for (i = rq.position; i + 1 < shadow_fill; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_fill--;
                end
            default:
                // Peek and the spare codes leave the stack alone.
                if (shadow_fill == 0)
                    st = ST_EMPTY;
        endcase
        rs.top    = (shadow_fill > 0) ? shadow_entries[shadow_fill - 1] : '0;
        rs.count  = POS_W'(shadow_fill);
        rs.status = st;
        return rs;
    endfunction

    // Queue one request word and track the fill level it should leave behind.
    task automatic queue_word(input logic [2:0] m, input int p, input logic [DATA_WIDTH-1:0] v);
        stack_req_t w;
        w.mode     = m;
        w.position = POS_W'(p);
        w.value    = v;
        pending_words.push_back(w);
        case (m)
            MODE_PUSH:   if (gen_fill < DEPTH) gen_fill++;
            MODE_POP:    if (gen_fill > 0) gen_fill--;
            MODE_INSERT: if (p <= gen_fill && gen_fill < DEPTH) gen_fill++;
            MODE_REMOVE: if (p < gen_fill) gen_fill--;
            default:     ;
        endcase
    endtask

    // Favour the extremes of the value range now and then.
    function automatic logic [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus: a directed walk over the edges, then random sequences that
    // swing the stack between empty and full, then wait for the drain.
    // ------------------------------------------------------------------------
    initial
    begin
        int  n;
        int  pick;
        bit  growing;

        // Empty-stack cases: pop, peek, remove, insert above the top.
        queue_word(MODE_POP, 0, pick_value());
        queue_word(MODE_PEEK, 0, pick_value());
        queue_word(MODE_REMOVE, 0, pick_value());
        queue_word(MODE_INSERT, 1, pick_value());
        // Insert at the bottom of an empty stack, then build a few entries.
        queue_word(MODE_INSERT, 0, '1);
        queue_word(MODE_PUSH, 0, '0);
        queue_word(MODE_INSERT, 0, $urandom);
        queue_word(MODE_INSERT, 3, $urandom);   // position equal to count: append
        queue_word(MODE_INSERT, 2, $urandom);   // middle
        queue_word(MODE_REMOVE, 5, $urandom);   // position equal to count: bad
        queue_word(MODE_REMOVE, 4, $urandom);   // top
        queue_word(MODE_REMOVE, 0, $urandom);   // bottom
        queue_word(MODE_REMOVE, 1, $urandom);   // middle
        queue_word(MODE_SPARE_LO, 0, $urandom);
        queue_word(MODE_SPARE_HI, 31, $urandom);
        queue_word(MODE_INSERT, 31, $urandom);
        // Fill to the brim and poke at the full edge.
        while (gen_fill < DEPTH)
            queue_word(MODE_PUSH, 0, pick_value());
        queue_word(MODE_PUSH, 0, $urandom);
        queue_word(MODE_INSERT, DEPTH, $urandom);
        queue_word(MODE_INSERT, DEPTH + 1, $urandom);
        queue_word(MODE_REMOVE, DEPTH, $urandom);
        queue_word(MODE_REMOVE, DEPTH - 1, $urandom);

        // Random part: mostly aimed growth and shrink runs, some noise.
        growing = 1'b0;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (gen_fill == DEPTH && $urandom_range(0, 2) == 0)
                growing = 1'b0;
            else if (gen_fill == 0 && $urandom_range(0, 2) == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 40) == 0)
                growing = !growing;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                queue_word(3'($urandom_range(0, 7)), $urandom_range(0, 31), pick_value());
            else if (pick < 12)
                queue_word(MODE_PEEK, $urandom_range(0, 31), pick_value());
            else if (growing && pick < 56)
                queue_word(MODE_PUSH, $urandom_range(0, 31), pick_value());
            else if (growing)
                queue_word(MODE_INSERT, $urandom_range(0, gen_fill), pick_value());
            else if (pick < 56)
                queue_word(MODE_POP, $urandom_range(0, 31), pick_value());
            else
                queue_word(MODE_REMOVE, (gen_fill > 0) ? $urandom_range(0, gen_fill - 1) : 0,
                           pick_value());
        end
        words_queued = pending_words.size();

        // Sample away from the rising edge so the driver's updates have settled.
        do
            @(negedge clk);
        while (words_taken != words_queued || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request driver: bursts of random length separated by random gaps. A
    // stalled word is held unchanged; an accepted word advances the shadow.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            mode       <= '0;
            position   <= '0;
            item_value <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_results.push_back(apply_stack_request({mode, position, item_value}));
                words_taken++;
            end

            if (req_valid && req_stall)
            begin
                // hold the stalled word as it is
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                next_word  = pending_words.pop_front();
                mode       <= next_word.mode;
                position   <= next_word.position;
                item_value <= next_word.value;
                req_valid  <= 1'b1;
                // At the end of a burst pick the next gap; a third of the
                // time none, so back-to-back bursts make long busy stretches.
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left--;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and stall pattern. Compare each accepted result word
    // with the oldest prediction; switch stall style every so often.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall    <= 1'b0;
            pattern_left = 0;
            stall_run    = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result word top=%h count=%0d status=%0d",
                             $time, top_value, entry_count, status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (top_value !== want.top)
                    begin
                        $display("%0t: top_value expected %h actual %h",
                                 $time, want.top, top_value);
                        mismatch_count++;
                    end
                    if (entry_count !== want.count)
                    begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.count, entry_count);
                        mismatch_count++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        mismatch_count++;
                    end
                end
            end

            if (pattern_left == 0)
            begin
                stall_style  = stall_style_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(30, 200);
            end
            else
                pattern_left--;

            case (stall_style)
                STALL_NONE:  rsp_stall <= 1'b0;
                STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                default:
                    // Long stall runs with open stretches between them.
                    if (stall_run > 0)
                    begin
                        stall_run--;
                        rsp_stall <= 1'b1;
                    end
                    else
                    begin
                        rsp_stall <= 1'b0;
                        if ($urandom_range(0, 7) == 0)
                            stall_run = $urandom_range(4, 15);
                    end
            endcase
        end
    end

    // Watchdog: drop the run if neither channel moves a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results still outstanding",
                     $time, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
